@@ design/tsd_pkg.sv @@
// Package for the TLV stream deframer: result codes, parser states, queue item type.
// No dependencies; every other design file imports it.
package tsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned HDR_CNT_W = 3;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEFT_W    = 31;

    localparam logic [1:0] STATUS_BODY  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST_TYPE_POS = 3'd3;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS      = 3'd7;

    typedef enum logic {
        ST_HEADER,
        ST_BODY
    } t_parse_state;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [WORD_W-1:0] message_type;
        logic [BYTE_W-1:0]       body_byte;
        logic                    last_of_message;
    } t_result;

endpackage

@@ design/tsd_front.sv @@
// Front end of the deframer: gathers headers, counts body bytes, classifies each byte.
// Depends on tsd_pkg; pushes finished results into tsd_queue.
module tsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_stream_byte,
    output logic            o_push,
    output tsd_pkg::t_result o_push_item
);
    import tsd_pkg::*;

    t_parse_state          r_state, n_state;
    logic [HDR_CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [WORD_W-1:0]     r_type, n_type;
    logic [WORD_W-1:0]     r_length, n_length;
    logic [LEFT_W-1:0]     r_left, n_left;

    logic                  body_last;
    logic [WORD_W-1:0]     full_length;

    assign body_last   = (r_left <= LEFT_W'(1));
    // length word as it stands once the eighth header byte lands
    assign full_length = {i_stream_byte, r_length[23:0]};

    // next state
    always_comb begin
        n_state = r_state;
        if (i_accept) begin
            unique case (r_state)
                ST_HEADER: begin
                    if (r_hdr_cnt == HDR_LAST_POS && !full_length[WORD_W-1] &&
                        full_length != '0) begin
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    if (body_last) begin
                        n_state = ST_HEADER;
                    end
                end
                default: n_state = ST_HEADER;
            endcase
        end
    end

    // datapath registers and result outputs
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_type      = r_type;
        n_length    = r_length;
        n_left      = r_left;
        o_push      = 1'b0;
        o_push_item = '{status: STATUS_BODY, message_type: r_type,
                        body_byte: i_stream_byte, last_of_message: 1'b1};
        if (i_accept) begin
            unique case (r_state)
                ST_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    unique case (r_hdr_cnt[1:0])
                        2'd0: begin
                            if (r_hdr_cnt[2]) n_length[7:0]   = i_stream_byte;
                            else              n_type[7:0]     = i_stream_byte;
                        end
                        2'd1: begin
                            if (r_hdr_cnt[2]) n_length[15:8]  = i_stream_byte;
                            else              n_type[15:8]    = i_stream_byte;
                        end
                        2'd2: begin
                            if (r_hdr_cnt[2]) n_length[23:16] = i_stream_byte;
                            else              n_type[23:16]   = i_stream_byte;
                        end
                        default: begin
                            if (r_hdr_cnt[2]) n_length[31:24] = i_stream_byte;
                            else              n_type[31:24]   = i_stream_byte;
                        end
                    endcase
                    if (r_hdr_cnt == HDR_LAST_POS) begin
                        if (full_length[WORD_W-1]) begin
                            o_push                = 1'b1;
                            o_push_item.status    = STATUS_ERROR;
                            o_push_item.body_byte = '0;
                        end else if (full_length == '0) begin
                            o_push                = 1'b1;
                            o_push_item.status    = STATUS_EMPTY;
                            o_push_item.body_byte = '0;
                        end else begin
                            n_left = full_length[LEFT_W-1:0];
                        end
                    end
                end
                ST_BODY: begin
                    o_push                      = 1'b1;
                    o_push_item.last_of_message = body_last;
                    n_left = body_last ? '0 : r_left - LEFT_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HEADER;
            r_hdr_cnt <= '0;
            r_type    <= '0;
            r_length  <= '0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_hdr_cnt <= n_hdr_cnt;
            r_type    <= n_type;
            r_length  <= n_length;
            r_left    <= n_left;
        end
    end

endmodule

@@ design/tsd_queue.sv @@
// Short result queue between the parser front end and the output stage.
// Depends on tsd_pkg for the item type; DEPTH must be a power of two, at least 2.
module tsd_queue #(
    parameter int unsigned DEPTH = tsd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tsd_pkg::t_result i_push_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output tsd_pkg::t_result o_item
);
    import tsd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ design/tsd_back.sv @@
// Output stage of the deframer: registered result held steady while stalled.
// Depends on tsd_pkg; pulls items from tsd_queue.
module tsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tsd_pkg::t_result    i_q_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_message_type,
    output logic [7:0]          o_body_byte,
    output logic                o_last_of_message
);
    import tsd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_item;

    // load whenever the register is empty or its item leaves this cycle
    assign o_pop   = i_q_valid && (!r_valid || !i_out_stall);
    assign n_valid = o_pop || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_status          = r_item.status;
    assign o_message_type    = r_item.message_type;
    assign o_body_byte       = r_item.body_byte;
    assign o_last_of_message = r_item.last_of_message;

endmodule

@@ design/tlv_stream_deframer_core.sv @@
// TLV stream deframer, top level: front end parser, result queue, output stage.
// Depends on tsd_pkg, tsd_front, tsd_queue and tsd_back.
//
// Usage:
//   Input channel: one stream byte per item on i_stream_byte, taken at an edge
//   where i_in_valid is high and o_in_stall is low. Each message is an 8-byte
//   header (32-bit type, 32-bit length, little-endian) followed by the body.
//   Output channel: o_out_valid / i_out_stall carry one result per body byte,
//   one empty-message result for a zero length and one error result for a
//   negative length; header bytes otherwise give no result.
//   Throughput: one byte per clock, sustained, while the receiver keeps up.
//   Each result is written into the queue at the edge where its byte is taken
//   and is loaded into the output register once older results have left the
//   queue and the output register is empty or its item leaves.
//   When the receiver stalls, the output register holds its item and the
//   queue (QUEUE_DEPTH items) absorbs new results; o_in_stall is high while
//   the queue is full and drops at the edge where the output stage takes an
//   item from it.
//   Reset (synchronous, active low) empties the queue and output register and
//   returns the parser to expecting a header.
module tlv_stream_deframer_core #(
    parameter int unsigned QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_stream_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_message_type,
    output logic [7:0]         o_body_byte,
    output logic               o_last_of_message
);
    import tsd_pkg::*;

    logic    accept;
    logic    push;
    t_result push_item;
    logic    q_full;
    logic    q_valid;
    t_result q_item;
    logic    pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    tsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_stream_byte (i_stream_byte),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    tsd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_message_type    (o_message_type),
        .o_body_byte       (o_body_byte),
        .o_last_of_message (o_last_of_message)
    );

endmodule
